// File: rtl/priority_two_queue_server_core_defines.svh
// Assertion macros for the priority two-queue server.
`ifndef PRIORITY_TWO_QUEUE_SERVER_CORE_DEFINES_SVH
`define PRIORITY_TWO_QUEUE_SERVER_CORE_DEFINES_SVH

// Property that must hold at every sampled edge outside reset.
`define PQS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pqs_pkg.sv
// Shared types, constants and helper functions for the priority two-queue server.
package pqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    localparam int CFG_W     = 5;
    localparam int MODE_W    = 2;
    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int OUTCOME_W = 3;
    localparam int STAT_W    = 32;
    localparam int SUM_W     = 48;

    localparam int ENTRY_W_DEF = ID_BITS_DEF + TIME_W;

    localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(16);

    localparam logic [MODE_W-1:0] MODE_HIGH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_ACCEPTED    = 3'd0,
        OUT_REFUSED     = 3'd1,
        OUT_IDLE        = 3'd2,
        OUT_SERVED_HIGH = 3'd3,
        OUT_SERVED_LOW  = 3'd4
    } outcome_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
        logic [STAT_W-1:0] r;
        r = (v == {STAT_W{1'b1}}) ? v : v + STAT_W'(1);
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [TIME_W-1:0] w);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W + 1)'(w);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

endpackage

// File: rtl/priority_two_queue_server_core.sv
// Strict-priority scheduler over two bounded FIFOs kept in RAM.
//
// Input channel (in_valid/in_stall) carries one transaction per request or tick:
// mode 0 pushes {item_id, now} into the high queue, mode 1 into the low queue,
// mode 2 or 3 is a service tick that pops high first, then low, else counts idle.
// Output channel (out_valid/out_stall) returns one result per input transaction,
// with the outcome, served id, wait time and all statistics after the update.
// cfg_wr_en/cfg_wr_data write the per-queue fill limit; write it only while idle.
// Requests and idle ticks show their result in the cycle after acceptance;
// ticks that pop go through ST_POP first, for the registered read of the queue RAM.
// One request per cycle unless stalled; a popping tick blocks input while in ST_POP.
// The result sits in an output register; the next transaction is taken in the
// cycle that register is drained. While out_stall holds a result, in_stall is high.
// Reset clears pointers, fill counts, statistics and sets the fill limit to 16;
// queue RAM contents are not cleared and are only read after being written.
module priority_two_queue_server_core #(
    parameter int QUEUE_DEPTH = pqs_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = pqs_pkg::ID_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pqs_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pqs_pkg::MODE_W-1:0]      mode,
    input  logic [pqs_pkg::ID_W-1:0]        item_id,
    input  logic [pqs_pkg::TIME_W-1:0]      now,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pqs_pkg::OUTCOME_W-1:0]   outcome,
    output logic [pqs_pkg::ID_W-1:0]        served_id,
    output logic [pqs_pkg::TIME_W-1:0]      wait_time,
    output logic [pqs_pkg::STAT_W-1:0]      high_accepted,
    output logic [pqs_pkg::STAT_W-1:0]      high_refused,
    output logic [pqs_pkg::STAT_W-1:0]      low_accepted,
    output logic [pqs_pkg::STAT_W-1:0]      low_refused,
    output logic [pqs_pkg::STAT_W-1:0]      high_served,
    output logic [pqs_pkg::STAT_W-1:0]      low_served,
    output logic [pqs_pkg::SUM_W-1:0]       high_wait_sum,
    output logic [pqs_pkg::SUM_W-1:0]       low_wait_sum,
    output logic [pqs_pkg::STAT_W-1:0]      idle_ticks
);

    import pqs_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ENTRY_W = ID_BITS + TIME_W;
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  limit_reg;
    logic [PTR_W-1:0]  high_head_reg, high_head_next, high_tail_reg, high_tail_next;
    logic [PTR_W-1:0]  low_head_reg, low_head_next, low_tail_reg, low_tail_next;
    logic [CNT_W-1:0]  high_count_reg, high_count_next, low_count_reg, low_count_next;

    logic [STAT_W-1:0] high_acc_reg, high_acc_next, high_ref_reg, high_ref_next;
    logic [STAT_W-1:0] low_acc_reg, low_acc_next, low_ref_reg, low_ref_next;
    logic [STAT_W-1:0] high_srv_reg, high_srv_next, low_srv_reg, low_srv_next;
    logic [STAT_W-1:0] idle_reg, idle_next;
    logic [SUM_W-1:0]  high_sum_reg, high_sum_next, low_sum_reg, low_sum_next;

    logic              out_valid_reg, out_valid_next;
    outcome_t          outcome_reg, outcome_next;
    logic [ID_W-1:0]   served_id_reg, served_id_next;
    logic [TIME_W-1:0] wait_time_reg, wait_time_next;
    logic              load_out;

    logic              pop_high_reg;
    logic [TIME_W-1:0] now_reg;

    logic              in_fire;
    logic              is_req;
    logic              any_queued;
    logic [CMP_W-1:0]  limit_eff;
    logic              high_room, low_room;
    logic [ID_BITS-1:0] id_in;
    logic [ENTRY_W-1:0] wr_entry;
    logic              high_we, low_we;
    logic [ENTRY_W-1:0] high_rd, low_rd, pop_entry;
    logic [TIME_W-1:0] pop_wait;

    assign in_stall   = !((state_reg == ST_IDLE) && (!out_valid_reg || !out_stall));
    assign in_fire    = in_valid && !in_stall;
    assign is_req     = mode inside {MODE_HIGH, MODE_LOW};
    assign any_queued = (high_count_reg != '0) || (low_count_reg != '0);

    assign limit_eff = (CMP_W'(limit_reg) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(limit_reg);
    assign high_room = CMP_W'(high_count_reg) < limit_eff;
    assign low_room  = CMP_W'(low_count_reg) < limit_eff;

    assign id_in    = ID_BITS'(item_id);
    assign wr_entry = {id_in, now};

    assign pop_entry = pop_high_reg ? high_rd : low_rd;
    assign pop_wait  = now_reg - pop_entry[TIME_W-1:0];

    pqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_high_ram (
        .clk     (clk),
        .wr_en   (high_we),
        .wr_addr (high_tail_reg),
        .wr_data (wr_entry),
        .rd_addr (high_head_reg),
        .rd_data (high_rd)
    );

    pqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_low_ram (
        .clk     (clk),
        .wr_en   (low_we),
        .wr_addr (low_tail_reg),
        .wr_data (wr_entry),
        .rd_addr (low_head_reg),
        .rd_data (low_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !is_req && any_queued)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        high_head_next  = high_head_reg;
        high_tail_next  = high_tail_reg;
        high_count_next = high_count_reg;
        low_head_next   = low_head_reg;
        low_tail_next   = low_tail_reg;
        low_count_next  = low_count_reg;
        high_acc_next   = high_acc_reg;
        high_ref_next   = high_ref_reg;
        low_acc_next    = low_acc_reg;
        low_ref_next    = low_ref_reg;
        high_srv_next   = high_srv_reg;
        low_srv_next    = low_srv_reg;
        idle_next       = idle_reg;
        high_sum_next   = high_sum_reg;
        low_sum_next    = low_sum_reg;
        high_we         = 1'b0;
        low_we          = 1'b0;
        load_out        = 1'b0;
        outcome_next    = outcome_reg;
        served_id_next  = '0;
        wait_time_next  = '0;
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_req)
                    begin
                        load_out = 1'b1;
                        if (mode == MODE_HIGH)
                        begin
                            if (high_room)
                            begin
                                high_we         = 1'b1;
                                high_tail_next  = ptr_inc(high_tail_reg);
                                high_count_next = high_count_reg + CNT_W'(1);
                                high_acc_next   = sat_inc(high_acc_reg);
                                outcome_next    = OUT_ACCEPTED;
                            end
                            else
                            begin
                                high_ref_next = sat_inc(high_ref_reg);
                                outcome_next  = OUT_REFUSED;
                            end
                        end
                        else
                        begin
                            if (low_room)
                            begin
                                low_we         = 1'b1;
                                low_tail_next  = ptr_inc(low_tail_reg);
                                low_count_next = low_count_reg + CNT_W'(1);
                                low_acc_next   = sat_inc(low_acc_reg);
                                outcome_next   = OUT_ACCEPTED;
                            end
                            else
                            begin
                                low_ref_next = sat_inc(low_ref_reg);
                                outcome_next = OUT_REFUSED;
                            end
                        end
                    end
                    else if (!any_queued)
                    begin
                        load_out     = 1'b1;
                        idle_next    = sat_inc(idle_reg);
                        outcome_next = OUT_IDLE;
                    end
                end
            end
            ST_POP:
            begin
                load_out       = 1'b1;
                served_id_next = ID_W'(pop_entry[TIME_W +: ID_BITS]);
                wait_time_next = pop_wait;
                if (pop_high_reg)
                begin
                    high_head_next  = ptr_inc(high_head_reg);
                    high_count_next = high_count_reg - CNT_W'(1);
                    high_srv_next   = sat_inc(high_srv_reg);
                    high_sum_next   = sat_add(high_sum_reg, pop_wait);
                    outcome_next    = OUT_SERVED_HIGH;
                end
                else
                begin
                    low_head_next  = ptr_inc(low_head_reg);
                    low_count_next = low_count_reg - CNT_W'(1);
                    low_srv_next   = sat_inc(low_srv_reg);
                    low_sum_next   = sat_add(low_sum_reg, pop_wait);
                    outcome_next   = OUT_SERVED_LOW;
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= LIMIT_RESET;
            high_head_reg  <= '0;
            high_tail_reg  <= '0;
            high_count_reg <= '0;
            low_head_reg   <= '0;
            low_tail_reg   <= '0;
            low_count_reg  <= '0;
            high_acc_reg   <= '0;
            high_ref_reg   <= '0;
            low_acc_reg    <= '0;
            low_ref_reg    <= '0;
            high_srv_reg   <= '0;
            low_srv_reg    <= '0;
            idle_reg       <= '0;
            high_sum_reg   <= '0;
            low_sum_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            high_head_reg  <= high_head_next;
            high_tail_reg  <= high_tail_next;
            high_count_reg <= high_count_next;
            low_head_reg   <= low_head_next;
            low_tail_reg   <= low_tail_next;
            low_count_reg  <= low_count_next;
            high_acc_reg   <= high_acc_next;
            high_ref_reg   <= high_ref_next;
            low_acc_reg    <= low_acc_next;
            low_ref_reg    <= low_ref_next;
            high_srv_reg   <= high_srv_next;
            low_srv_reg    <= low_srv_next;
            idle_reg       <= idle_next;
            high_sum_reg   <= high_sum_next;
            low_sum_reg    <= low_sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            now_reg      <= now;
            pop_high_reg <= (high_count_reg != '0);
        end
        if (load_out)
        begin
            outcome_reg   <= outcome_next;
            served_id_reg <= served_id_next;
            wait_time_reg <= wait_time_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign outcome       = outcome_reg;
    assign served_id     = served_id_reg;
    assign wait_time     = wait_time_reg;
    assign high_accepted = high_acc_reg;
    assign high_refused  = high_ref_reg;
    assign low_accepted  = low_acc_reg;
    assign low_refused   = low_ref_reg;
    assign high_served   = high_srv_reg;
    assign low_served    = low_srv_reg;
    assign high_wait_sum = high_sum_reg;
    assign low_wait_sum  = low_sum_reg;
    assign idle_ticks    = idle_reg;

endmodule

// File: rtl/pqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pqs_ram #(
    parameter int WIDTH = pqs_pkg::ENTRY_W_DEF,
    parameter int DEPTH = pqs_pkg::QUEUE_DEPTH_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/pqs_checker.sv
// Port-level checker for the priority two-queue server, bound to the top level.
`include "priority_two_queue_server_core_defines.svh"

module pqs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [pqs_pkg::OUTCOME_W-1:0] outcome,
    input logic [pqs_pkg::ID_W-1:0]      served_id,
    input logic [pqs_pkg::TIME_W-1:0]    wait_time,
    input logic [pqs_pkg::STAT_W-1:0]    high_accepted,
    input logic [pqs_pkg::STAT_W-1:0]    idle_ticks
);

    import pqs_pkg::*;

    `PQS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(outcome) && $stable(served_id) && $stable(wait_time),
        "stalled result changed")

    `PQS_ASSERT(a_backpressure, clk, rst_n, !(out_valid && out_stall) || in_stall,
        "input taken while result is stalled")

    `PQS_ASSERT(a_no_serve_zero, clk, rst_n,
        !(out_valid && (outcome == OUT_ACCEPTED || outcome == OUT_REFUSED ||
        outcome == OUT_IDLE)) || (served_id == '0 && wait_time == '0),
        "non-served result carries id or wait")

    `PQS_ASSERT_NEXT(a_stats_monotone, clk, rst_n, 1'b1,
        high_accepted >= $past(high_accepted) && idle_ticks >= $past(idle_ticks),
        "statistics counter decreased")

endmodule

bind priority_two_queue_server_core pqs_checker u_pqs_checker (.*);
